[rtl/core/unicode_escape_to_utf8_defines.svh]
// assertion macros used by the unicode escape converter checker
`ifndef UNICODE_ESCAPE_TO_UTF8_DEFINES_SVH
`define UNICODE_ESCAPE_TO_UTF8_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define UE2U_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define UE2U_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/ue2u_pkg.sv]
// shared types, constants and helper functions of the unicode escape converter
package ue2u_pkg;

   localparam int unsigned PendDepth  = 10;
   localparam int unsigned CountWidth = 4;

   localparam logic [CountWidth-1:0] EscShort = 4'd6;
   localparam logic [CountWidth-1:0] EscLong  = 4'd10;

   localparam logic [7:0] CharBackslash = 8'h5C;
   localparam logic [7:0] CharLowerU    = 8'h75;
   localparam logic [7:0] CharUpperU    = 8'h55;

   localparam logic [31:0] Max1Byte = 32'h0000_007F;
   localparam logic [31:0] Max2Byte = 32'h0000_07FF;
   localparam logic [31:0] Max3Byte = 32'h0000_FFFF;

   localparam logic [7:0] Lead2    = 8'hC0;
   localparam logic [7:0] Lead3    = 8'hE0;
   localparam logic [7:0] Lead4    = 8'hF0;
   localparam logic [7:0] ContMark = 8'h80;

   // what the scan finds at the head of the pending buffer
   typedef enum logic [1:0] {
      ACT_EMPTY,
      ACT_WAIT,
      ACT_PLAIN,
      ACT_ESC
   } act_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic emit_plain;
      logic esc_latch;
      logic emit_utf;
   } ue2u_cmd_type;

   // datapath to controller
   typedef struct packed {
      act_type act;
      logic    utf_final;
   } ue2u_stat_type;

   function automatic logic hex_ok(input logic [7:0] c);
      return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      if (c inside {[8'h30:8'h39]}) begin
         v = c - 8'h30;
      end else if (c inside {[8'h61:8'h66]}) begin
         v = c - 8'h57;
      end else begin
         v = c - 8'h37;
      end
      return v[3:0];
   endfunction

endpackage

[rtl/core/ue2u_datapath.sv]
// pending byte buffer, escape decode, utf-8 byte select and output data register
module ue2u_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  ue2u_pkg::ue2u_cmd_type cmd,
   output ue2u_pkg::ue2u_stat_type stat,
   input  logic [7:0]             in_byte,
   input  logic                   in_last,
   output logic [7:0]             out_byte,
   output logic                   out_last
);
   import ue2u_pkg::*;

   logic [7:0]            pend_ff [PendDepth];
   logic [7:0]            pend_in [PendDepth];
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  last_ff, last_in;
   logic [31:0]           cp_ff, cp_in;
   logic [1:0]            len_ff, len_in;
   logic [1:0]            idx_ff, idx_in;
   logic [7:0]            out_byte_ff, out_byte_in;
   logic                  out_last_ff, out_last_in;

   logic [3:0]            nib [PendDepth];
   logic [PendDepth-1:0]  bad_vec;
   logic                  esc_long;
   logic [CountWidth-1:0] esc_len;
   logic [31:0]           cp_new;
   logic [1:0]            len_new;
   logic [1:0]            cont_pos;
   logic [7:0]            lead_byte;
   logic [7:0]            cont_byte;
   logic [7:0]            utf_byte;
   act_type               scan_act;
   logic                  utf_final;

   // hex value of every buffer entry, hex digit check of the held bytes from index 2 on
   always_comb begin
      for (int i = 0; i < PendDepth; i++) begin
         nib[i]     = hex_val(pend_ff[i]);
         bad_vec[i] = (i >= 2) && (CountWidth'(i) < count_ff) && !hex_ok(pend_ff[i]);
      end
   end

   // escape form and decoded code point
   assign esc_long = (pend_ff[1] == CharUpperU);
   assign esc_len  = esc_long ? EscLong : EscShort;
   assign cp_new   = esc_long ?
                     {nib[2], nib[3], nib[4], nib[5], nib[6], nib[7], nib[8], nib[9]} :
                     {16'h0000, nib[2], nib[3], nib[4], nib[5]};

   // utf-8 length minus one
   always_comb begin
      if (cp_new <= Max1Byte) begin
         len_new = 2'd0;
      end else if (cp_new <= Max2Byte) begin
         len_new = 2'd1;
      end else if (cp_new <= Max3Byte) begin
         len_new = 2'd2;
      end else begin
         len_new = 2'd3;
      end
   end

   // classify the head of the buffer
   always_comb begin
      if (count_ff == '0) begin
         scan_act = ACT_EMPTY;
      end else if (pend_ff[0] != CharBackslash) begin
         scan_act = ACT_PLAIN;
      end else if (count_ff == 4'd1) begin
         scan_act = last_ff ? ACT_PLAIN : ACT_WAIT;
      end else if (pend_ff[1] != CharLowerU && pend_ff[1] != CharUpperU) begin
         scan_act = ACT_PLAIN;
      end else if (|bad_vec) begin
         scan_act = ACT_PLAIN;
      end else if (count_ff >= esc_len) begin
         scan_act = ACT_ESC;
      end else begin
         scan_act = last_ff ? ACT_PLAIN : ACT_WAIT;
      end
   end

   // utf-8 byte at the current index of the latched code point
   assign cont_pos = len_ff - idx_ff;

   always_comb begin
      case (len_ff)
         2'd0: lead_byte = cp_ff[7:0];
         2'd1: lead_byte = Lead2 | {3'b000, cp_ff[10:6]};
         2'd2: lead_byte = Lead3 | {4'h0, cp_ff[15:12]};
         default: lead_byte = Lead4 | cp_ff[25:18];
      endcase
   end

   always_comb begin
      case (cont_pos)
         2'd1: cont_byte = ContMark | {2'b00, cp_ff[11:6]};
         2'd2: cont_byte = ContMark | {2'b00, cp_ff[17:12]};
         default: cont_byte = ContMark | {2'b00, cp_ff[5:0]};
      endcase
   end

   assign utf_byte  = (idx_ff == 2'd0) ? lead_byte : cont_byte;
   assign utf_final = (idx_ff == len_ff);

   // status to the controller
   assign stat = {scan_act, utf_final};

   // next state of buffer, code point and output data
   always_comb begin
      pend_in     = pend_ff;
      count_in    = count_ff;
      last_in     = last_ff;
      cp_in       = cp_ff;
      len_in      = len_ff;
      idx_in      = idx_ff;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;

      // append the transferred byte
      if (cmd.load) begin
         for (int i = 0; i < PendDepth; i++) begin
            if (count_ff == CountWidth'(i)) begin
               pend_in[i] = in_byte;
            end
         end
         count_in = count_ff + 4'd1;
         last_in  = in_last;
      end

      // pass the head byte on and drop it
      if (cmd.emit_plain) begin
         for (int i = 0; i < PendDepth - 1; i++) begin
            pend_in[i] = pend_ff[i+1];
         end
         count_in    = count_ff - 4'd1;
         out_byte_in = pend_ff[0];
         out_last_in = last_ff && (count_ff == 4'd1);
      end

      // latch a complete escape and drop its bytes
      if (cmd.esc_latch) begin
         for (int i = 0; i < PendDepth - int'(EscShort); i++) begin
            pend_in[i] = pend_ff[i+int'(EscShort)];
         end
         count_in = count_ff - esc_len;
         cp_in    = cp_new;
         len_in   = len_new;
         idx_in   = 2'd0;
      end

      // one utf-8 byte out
      if (cmd.emit_utf) begin
         out_byte_in = utf_byte;
         out_last_in = last_ff && (count_ff == '0) && utf_final;
         idx_in      = idx_ff + 2'd1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      last_ff     <= last_in;
      cp_ff       <= cp_in;
      len_ff      <= len_in;
      idx_ff      <= idx_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign out_byte = out_byte_ff;
   assign out_last = out_last_ff;

endmodule

[rtl/core/ue2u_ctrl.sv]
// controller state machine and output valid register of the unicode escape converter
module ue2u_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output ue2u_pkg::ue2u_cmd_type  cmd,
   input  ue2u_pkg::ue2u_stat_type stat
);
   import ue2u_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // output register can take a byte this cycle
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            case (stat.act)
               ACT_PLAIN: begin
                  cmd.emit_plain = slot_free;
               end
               ACT_ESC: begin
                  cmd.esc_latch = 1'b1;
                  state_in      = ST_EMIT;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_EMIT: begin
            if (slot_free) begin
               cmd.emit_utf = 1'b1;
               if (stat.utf_final) begin
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output valid is set by emitted bytes and cleared by transfers
   always_comb begin
      if (cmd.emit_plain || cmd.emit_utf) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

[rtl/core/unicode_escape_to_utf8.sv]
// top level of the backslash-u / backslash-U escape to utf-8 stream converter
//
//   channel | dir | tdata          | tlast
//   req_    | in  | [7:0] in_byte  | in_last
//   rsp_    | out | [7:0] out_byte | out_last
//
// each input byte is loaded while idle and then scanned from the buffer head; a completed
// escape is latched and its utf-8 bytes are emitted in turn before the scan goes on.
// held bytes of a failed escape are rescanned one per cycle from the head unless stalled.
// reset (synchronous, active high) empties the buffer and the output register.
// rsp_tready low only holds the output register; the scan waits on it.
module unicode_escape_to_utf8 (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast
);
   import ue2u_pkg::*;

   ue2u_cmd_type  cmd;
   ue2u_stat_type stat;

   // sequencing
   ue2u_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   // buffer and conversion
   ue2u_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .in_byte  (req_tdata),
      .in_last  (req_tlast),
      .out_byte (rsp_tdata),
      .out_last (rsp_tlast)
   );

endmodule

[rtl/core/ue2u_checker.sv]
// port-level checker of the unicode escape converter and its bind
`include "unicode_escape_to_utf8_defines.svh"

module ue2u_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // stalled result stays offered and unchanged
   `UE2U_ASSERT_NEXT(a_rsp_hold_valid, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp_tvalid dropped while stalled")
   `UE2U_ASSERT_NEXT(a_rsp_hold_data, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tlast), "rsp payload changed while stalled")

   // an accepted byte is always scanned before the next one is taken
   `UE2U_ASSERT_NEXT(a_req_scan_after_transfer, clock, reset, req_tvalid && req_tready, !req_tready, "input taken again without a scan cycle")

   // results only appear from scanning, never while waiting for input
   `UE2U_ASSERT_SAME(a_rsp_from_scan, clock, reset, $rose(rsp_tvalid), $past(!req_tready), "result appeared while idle")

endmodule

bind unicode_escape_to_utf8 ue2u_checker u_ue2u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
